>>> rtl/core/i2c_bit_level_master_defines.svh
// ----------------------------------------------------------------------------
// I2C bit-level master: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_BIT_LEVEL_MASTER_DEFINES_SVH
`define I2C_BIT_LEVEL_MASTER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge out of reset
`define I2C_BLM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset
`define I2C_BLM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/i2c_blm_pkg.sv
// ----------------------------------------------------------------------------
// I2C bit-level master package
// Phase and command codes, register indexes and the structs between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package i2c_blm_pkg;

    localparam int unsigned TICK_W = 16;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned BIT_W  = 4;

    localparam logic [TICK_W-1:0] BIT_PHASE_RESET  = 16'd80;
    localparam logic [TICK_W-1:0] STOP_PHASE_RESET = 16'd40;
    localparam logic [BIT_W-1:0]  BITS_PER_BYTE    = 4'd8;

    // Byte-level commands
    typedef enum logic [2:0] {
        OP_NONE      = 3'd0,
        OP_START     = 3'd1,
        OP_WRITE     = 3'd2,
        OP_READ_ACK  = 3'd3,
        OP_READ_NACK = 3'd4,
        OP_STOP      = 3'd5
    } op_t;

    // Configuration register indexes
    typedef enum logic {
        REG_BIT_PHASE  = 1'b0,
        REG_STOP_PHASE = 1'b1
    } reg_idx_t;

    // Bus sequencing phases
    typedef enum logic [4:0] {
        PH_IDLE   = 5'd0,
        PH_ST_A   = 5'd1,
        PH_ST_B   = 5'd2,
        PH_SP_1   = 5'd3,
        PH_SP_2   = 5'd4,
        PH_SP_3   = 5'd5,
        PH_SP_4   = 5'd6,
        PH_W_LO   = 5'd7,
        PH_W_HI   = 5'd8,
        PH_WA_LO  = 5'd9,
        PH_WA_HI  = 5'd10,
        PH_WA_END = 5'd11,
        PH_R_LO   = 5'd12,
        PH_R_HI   = 5'd13,
        PH_RK_LO  = 5'd14,
        PH_RK_HI  = 5'd15
    } phase_t;

    typedef struct packed {
        logic [TICK_W-1:0] bit_len;
        logic [TICK_W-1:0] stop_len;
    } cfg_t;

    typedef struct packed {
        logic              acked;
        logic [BYTE_W-1:0] read_data;
        logic              done;
        logic              busy;
        logic              sda_drive;
        logic              sda;
        logic              scl;
    } res_t;

endpackage

`default_nettype wire

>>> rtl/core/i2c_blm_cfg.sv
// ----------------------------------------------------------------------------
// I2C bit-level master configuration registers
// Holds the bit phase and stop phase lengths written over the plain port.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_blm_cfg
    import i2c_blm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_addr,
    input  wire logic [TICK_W-1:0] cfg_wdata,
    output cfg_t                   cfg
);

    logic [TICK_W-1:0] bit_len_reg;
    logic [TICK_W-1:0] stop_len_reg;

    // Capture register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_len_reg  <= BIT_PHASE_RESET;
            stop_len_reg <= STOP_PHASE_RESET;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_addr))
                REG_BIT_PHASE:  bit_len_reg  <= cfg_wdata;
                REG_STOP_PHASE: stop_len_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    assign cfg.bit_len  = bit_len_reg;
    assign cfg.stop_len = stop_len_reg;

endmodule

`default_nettype wire

>>> rtl/core/i2c_blm_seq.sv
// ----------------------------------------------------------------------------
// I2C bit-level master phase sequencer
// Advances the bus phase state by one tick per accepted transaction and
// forms that tick's pin levels and status.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_bit_level_master_defines.svh"

module i2c_blm_seq
    import i2c_blm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [2:0]        operation,
    input  wire logic [BYTE_W-1:0] write_data,
    input  wire logic              sda_in,
    input  wire cfg_t              cfg,
    output res_t                   res
);

    phase_t            ph_reg,  ph_next;
    logic [TICK_W-1:0] tc_reg,  tc_next;
    logic [BIT_W-1:0]  bi_reg,  bi_next;
    logic [BYTE_W-1:0] sb_reg,  sb_next;
    logic [BYTE_W-1:0] rb_reg,  rb_next;
    logic              as_reg,  as_next;
    logic              ats_reg, ats_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic              drv_reg, drv_next;

    logic              enter_en;
    phase_t            enter_ph;
    logic              done;
    logic [TICK_W-1:0] len;
    logic              stop_ph;

    // Hold state between ticks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg  <= PH_IDLE;
            tc_reg  <= '0;
            bi_reg  <= '0;
            sb_reg  <= '0;
            rb_reg  <= '0;
            as_reg  <= 1'b0;
            ats_reg <= 1'b0;
            scl_reg <= 1'b1;
            sda_reg <= 1'b1;
            drv_reg <= 1'b1;
        end
        else if (step)
        begin
            ph_reg  <= ph_next;
            tc_reg  <= tc_next;
            bi_reg  <= bi_next;
            sb_reg  <= sb_next;
            rb_reg  <= rb_next;
            as_reg  <= as_next;
            ats_reg <= ats_next;
            scl_reg <= scl_next;
            sda_reg <= sda_next;
            drv_reg <= drv_next;
        end
    end

    // Pick the phase length: stop phases use the stop length
    assign stop_ph = (ph_reg == PH_SP_1) || (ph_reg == PH_SP_2) ||
                     (ph_reg == PH_SP_3) || (ph_reg == PH_SP_4);
    assign len     = stop_ph ? cfg.stop_len : cfg.bit_len;

    // Next phase, counters and pin levels
    always_comb
    begin
        ph_next  = ph_reg;
        tc_next  = tc_reg;
        bi_next  = bi_reg;
        sb_next  = sb_reg;
        rb_next  = rb_reg;
        as_next  = as_reg;
        ats_next = ats_reg;
        scl_next = scl_reg;
        sda_next = sda_reg;
        drv_next = drv_reg;
        enter_en = 1'b0;
        enter_ph = PH_IDLE;
        done     = 1'b0;

        if (ph_reg == PH_IDLE)
        begin
            // Launch a command
            case (op_t'(operation))
                OP_START:
                begin
                    enter_en = 1'b1;
                    enter_ph = PH_ST_A;
                end
                OP_WRITE:
                begin
                    sb_next  = write_data;
                    bi_next  = '0;
                    enter_en = 1'b1;
                    enter_ph = PH_W_LO;
                end
                OP_READ_ACK, OP_READ_NACK:
                begin
                    sb_next  = '0;
                    bi_next  = '0;
                    ats_next = (op_t'(operation) == OP_READ_ACK);
                    enter_en = 1'b1;
                    enter_ph = PH_R_LO;
                end
                OP_STOP:
                begin
                    enter_en = 1'b1;
                    enter_ph = PH_SP_1;
                end
                default: ;
            endcase
        end
        else
        begin
            tc_next = tc_reg + 1'b1;
            if (tc_next >= len)
            begin
                // End the current phase
                case (ph_reg)
                    PH_ST_A:
                    begin
                        enter_en = 1'b1;
                        enter_ph = PH_ST_B;
                    end
                    PH_SP_1:
                    begin
                        enter_en = 1'b1;
                        enter_ph = PH_SP_2;
                    end
                    PH_SP_2:
                    begin
                        enter_en = 1'b1;
                        enter_ph = PH_SP_3;
                    end
                    PH_SP_3:
                    begin
                        enter_en = 1'b1;
                        enter_ph = PH_SP_4;
                    end
                    PH_W_LO:
                    begin
                        enter_en = 1'b1;
                        enter_ph = PH_W_HI;
                    end
                    PH_W_HI:
                    begin
                        sb_next  = {sb_reg[BYTE_W-2:0], 1'b0};
                        bi_next  = bi_reg + 1'b1;
                        enter_en = 1'b1;
                        enter_ph = (bi_next >= BITS_PER_BYTE) ? PH_WA_LO : PH_W_LO;
                    end
                    PH_WA_LO:
                    begin
                        enter_en = 1'b1;
                        enter_ph = PH_WA_HI;
                    end
                    PH_WA_HI:
                    begin
                        as_next  = !sda_in;
                        enter_en = 1'b1;
                        enter_ph = PH_WA_END;
                    end
                    PH_WA_END:
                    begin
                        sda_next = 1'b1;
                        drv_next = 1'b1;
                        done     = 1'b1;
                    end
                    PH_R_LO:
                    begin
                        enter_en = 1'b1;
                        enter_ph = PH_R_HI;
                    end
                    PH_R_HI:
                    begin
                        sb_next  = {sb_reg[BYTE_W-2:0], sda_in};
                        bi_next  = bi_reg + 1'b1;
                        enter_en = 1'b1;
                        if (bi_next >= BITS_PER_BYTE)
                        begin
                            rb_next  = sb_next;
                            enter_ph = PH_RK_LO;
                        end
                        else
                        begin
                            enter_ph = PH_R_LO;
                        end
                    end
                    PH_RK_LO:
                    begin
                        enter_en = 1'b1;
                        enter_ph = PH_RK_HI;
                    end
                    PH_RK_HI:
                    begin
                        scl_next = 1'b0;
                        done     = 1'b1;
                    end
                    default:
                    begin
                        done = 1'b1;
                    end
                endcase
            end
        end

        // Complete the command and fall back to idle
        if (done)
        begin
            ph_next = PH_IDLE;
            tc_next = '0;
        end

        // Enter a new phase and set its pins
        if (enter_en)
        begin
            ph_next = enter_ph;
            tc_next = '0;
            case (enter_ph)
                PH_ST_A:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                    drv_next = 1'b1;
                end
                PH_ST_B:
                begin
                    sda_next = 1'b0;
                    drv_next = 1'b1;
                end
                PH_SP_1:  scl_next = 1'b0;
                PH_SP_2:
                begin
                    sda_next = 1'b0;
                    drv_next = 1'b1;
                end
                PH_SP_3:  scl_next = 1'b1;
                PH_SP_4:
                begin
                    sda_next = 1'b1;
                    drv_next = 1'b1;
                end
                PH_W_LO:
                begin
                    scl_next = 1'b0;
                    sda_next = sb_next[BYTE_W-1];
                    drv_next = 1'b1;
                end
                PH_W_HI:  scl_next = 1'b1;
                PH_WA_LO:
                begin
                    scl_next = 1'b0;
                    drv_next = 1'b0;
                end
                PH_WA_HI: scl_next = 1'b1;
                PH_WA_END: scl_next = 1'b0;
                PH_R_LO:
                begin
                    scl_next = 1'b0;
                    drv_next = 1'b0;
                end
                PH_R_HI:  scl_next = 1'b1;
                PH_RK_LO:
                begin
                    scl_next = 1'b0;
                    sda_next = !ats_next;
                    drv_next = 1'b1;
                end
                PH_RK_HI: scl_next = 1'b1;
                default:  ph_next = PH_IDLE;
            endcase
        end
    end

    // Result of this tick
    assign res.scl       = scl_next;
    assign res.sda       = sda_next;
    assign res.sda_drive = drv_next;
    assign res.busy      = (ph_next != PH_IDLE);
    assign res.done      = done;
    assign res.read_data = rb_next;
    assign res.acked     = as_next;

    // Completion only ever ends a command that was in progress
    `I2C_BLM_ASSERT_NOW(a_done_from_busy, done, ph_reg != PH_IDLE,
        "done raised while idle")

    // An idle tick without a command keeps the sequencer idle
    `I2C_BLM_ASSERT_NEXT(a_idle_holds, step && ph_reg == PH_IDLE &&
        op_t'(operation) == OP_NONE, ph_reg == PH_IDLE, "idle left without a command")

    // Clock low throughout every low data or ack phase
    `I2C_BLM_ASSERT_NOW(a_scl_low, ph_reg == PH_W_LO || ph_reg == PH_R_LO ||
        ph_reg == PH_WA_LO || ph_reg == PH_RK_LO, !scl_reg, "scl high in a low phase")

    // Bit counter stays within one byte while data bits are clocked
    `I2C_BLM_ASSERT_NOW(a_bit_range, ph_reg == PH_W_LO || ph_reg == PH_R_LO,
        bi_reg < BITS_PER_BYTE, "bit index past the byte")

endmodule

`default_nettype wire

>>> rtl/core/i2c_blm_out.sv
// ----------------------------------------------------------------------------
// I2C bit-level master result stage
// Registers each tick's result and offers it on the master-side stream.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_blm_out
    import i2c_blm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire res_t        res,
    output logic             in_ready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata
);

    logic valid_reg;
    res_t res_reg;

    // Accept a new result whenever the held one is empty or leaving
    assign in_ready = !valid_reg || m_tready;

    // Track the held result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= load;
        end
    end

    // Capture the payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, res_reg};

endmodule

`default_nettype wire

>>> rtl/core/i2c_bit_level_master.sv
// ----------------------------------------------------------------------------
// I2C bit-level master
// Tick-driven I2C master that sequences SCL and SDA for byte-level commands.
// ----------------------------------------------------------------------------
// Use: every slave-side transaction is one bus tick. It carries a command
// (none, start, write, read with ack, read with nack, stop), the byte to
// write and the sampled SDA level. Each accepted tick yields exactly one
// master-side transaction with the pin levels, busy, done, the last read
// byte and the last write ack. Commands offered while busy are ignored.
// Output: a tick's result is registered and offered the cycle after acceptance.
// Throughput: one tick per cycle unless the master side holds off; the phase
// state updates in one pass of logic between the state and result registers.
// Stall: while the master side holds off, one result waits in the result
// register and s_tready drops, so no tick is lost; s_tready is high again
// in the cycle the held result is taken.
// Reset: SCL high, SDA driven high, idle, counters and bytes cleared, phase
// lengths 80 (bit) and 40 (stop) ticks. The user must write configuration
// with cfg_we only while no command is in progress; the block does not check.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_bit_level_master
    import i2c_blm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    // Slave side
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] write_data, [8] sda_in, zero fill
    input  wire logic [2:0]  s_tuser,   // [2:0] operation
    // Master side
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [0] scl_out, [1] sda_out, [2] sda_drive,
                                        // [3] busy_res, [4] done_res,
                                        // [12:5] read_data, [13] acked, zero fill
);

    cfg_t cfg;
    res_t res;
    logic in_ready;
    logic load;

    assign s_tready = in_ready;
    assign load     = s_tvalid && in_ready;

    // Phase length registers
    i2c_blm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Bus phase sequencer
    i2c_blm_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (load),
        .operation  (s_tuser),
        .write_data (s_tdata[7:0]),
        .sda_in     (s_tdata[8]),
        .cfg        (cfg),
        .res        (res)
    );

    // Result register and master-side handshake
    i2c_blm_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .res      (res),
        .in_ready (in_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
